FILE: rtl/cmsh_pkg.sv
// Package for the circular mean heading smoother: shared types, fixed-point
// widths, angle constants and the CORDIC arctangent table.
// No dependencies; every other file of the block but cmsh_ram imports it.
package cmsh_pkg;

    localparam int HEADING_W    = 17;
    localparam int SUM_W        = 23;
    localparam int TRIG_W       = 16;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = 5;
    localparam int WIN_W        = 6;
    localparam int HALF_W       = 5;
    localparam int PEND_DEPTH   = 32;
    localparam int PEND_AW      = 5;

    // Angles in hundredths of a degree.
    localparam logic signed [17:0] FULL_TURN    = 18'sd36000;
    localparam logic signed [17:0] HALF_TURN    = 18'sd18000;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd9000;

    // Half turn in CORDIC angle units (1/65536 hundredth of a degree).
    localparam logic signed [CORDIC_W-1:0] HALF_TURN_Z = 34'sd1179648000;
    // Gain-corrected start vector for the rotation mode.
    localparam logic signed [CORDIC_W-1:0] X_START     = 34'sd652032875;

    localparam logic [28:0] ATAN_TAB [CORDIC_STEPS] = '{
        29'd294912000, 29'd174096719, 29'd91987925, 29'd46694507,
        29'd23437865,  29'd11730358,  29'd5866610,  29'd2933484,
        29'd1466766,   29'd733385,    29'd366693,   29'd183347,
        29'd91674,     29'd45837,     29'd22918,    29'd11459,
        29'd5730,      29'd2865
    };

    typedef logic signed [HEADING_W-1:0] t_heading;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic signed [TRIG_W-1:0]    t_trig;

    typedef struct packed {
        t_heading heading;
        logic     last;
    } t_item;

    typedef struct packed {
        t_heading heading;
        logic     smoothed;
        logic     last;
    } t_result;

    typedef struct packed {
        logic     vec;
        t_heading angle;
        t_sum     xs;
        t_sum     ys;
    } t_cordic_req;

    typedef struct packed {
        t_trig cos_v;
        t_trig sin_v;
        t_trig angle;
    } t_cordic_rsp;

endpackage

FILE: rtl/cmsh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cmsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cmsh_front.sv
// Front part: a two-entry request queue between the input stream and the
// back sequencer. Depends on cmsh_pkg.
module cmsh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cmsh_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output cmsh_pkg::t_item o_item,
    input  logic           i_pop
);
    import cmsh_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

FILE: rtl/cmsh_cordic.sv
// Shared iterative CORDIC: rotation mode gives cosine and sine in Q1.15,
// vectoring mode gives the angle of a summed vector. Depends on cmsh_pkg.
module cmsh_cordic (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  cmsh_pkg::t_cordic_req   i_req,
    output logic                    o_done,
    output cmsh_pkg::t_cordic_rsp   o_rsp
);
    import cmsh_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_MOD  = 5'b00010,
        C_FOLD = 5'b00100,
        C_ITER = 5'b01000,
        C_POST = 5'b10000
    } t_cstate;

    t_cstate                    r_state;
    t_cstate                    n_state;
    logic                       r_vec;
    logic                       r_neg;
    logic                       r_zero;
    logic signed [17:0]         r_r;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic [STEP_W-1:0]          r_i;
    logic                       r_done;
    t_cordic_rsp                r_rsp;

    logic signed [CORDIC_W-1:0] xe;
    logic signed [CORDIC_W-1:0] ye;
    logic signed [17:0]         a_ext;
    logic signed [17:0]         fold_a;
    logic signed [17:0]         fold_t;
    logic                       fold_neg;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] at;
    logic signed [CORDIC_W-1:0] xr;
    logic signed [CORDIC_W-1:0] yr;
    logic signed [CORDIC_W-1:0] zr;
    t_trig                      c_cl;
    t_trig                      s_cl;
    t_trig                      z_cl;

    always_comb begin
        xe    = {{3{i_req.xs[SUM_W-1]}}, i_req.xs, 8'b0};
        ye    = {{3{i_req.ys[SUM_W-1]}}, i_req.ys, 8'b0};
        a_ext = 18'(i_req.angle);
        // Bring the reduced angle into the right half plane.
        fold_a = (r_r >= HALF_TURN) ? r_r - FULL_TURN : r_r;
        if (fold_a > QUARTER_TURN) begin
            fold_t   = fold_a - HALF_TURN;
            fold_neg = 1'b1;
        end else if (fold_a < -QUARTER_TURN) begin
            fold_t   = fold_a + HALF_TURN;
            fold_neg = 1'b1;
        end else begin
            fold_t   = fold_a;
            fold_neg = 1'b0;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = {5'b0, ATAN_TAB[r_i]};
        xr = (r_x + 34'sd16384) >>> 15;
        yr = (r_y + 34'sd16384) >>> 15;
        zr = (r_z + 34'sd32768) >>> 16;
        priority if (xr > 34'sd32767) c_cl = 16'sd32767;
        else if (xr < -34'sd32767)    c_cl = -16'sd32767;
        else                          c_cl = xr[TRIG_W-1:0];
        priority if (yr > 34'sd32767) s_cl = 16'sd32767;
        else if (yr < -34'sd32767)    s_cl = -16'sd32767;
        else                          s_cl = yr[TRIG_W-1:0];
        priority if (zr > 34'sd18000) z_cl = 16'sd18000;
        else if (zr < -34'sd18000)    z_cl = -16'sd18000;
        else                          z_cl = zr[TRIG_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_state = i_req.vec ? C_ITER : C_MOD;
                end
            end
            C_MOD:  n_state = C_FOLD;
            C_FOLD: n_state = C_ITER;
            C_ITER: begin
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = C_POST;
                end
            end
            C_POST: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_POST);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_vec <= i_req.vec;
                    r_i   <= '0;
                    r_r   <= (a_ext < 18'sd0) ? a_ext + FULL_TURN : a_ext;
                    r_zero <= (i_req.xs == '0) && (i_req.ys == '0);
                    if (i_req.xs[SUM_W-1]) begin
                        r_x <= -xe;
                        r_y <= -ye;
                        r_z <= i_req.ys[SUM_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
                    end else begin
                        r_x <= xe;
                        r_y <= ye;
                        r_z <= '0;
                    end
                end
            end
            C_MOD: begin
                if (r_r < 18'sd0) begin
                    r_r <= r_r + FULL_TURN;
                end else if (r_r >= FULL_TURN) begin
                    r_r <= r_r - FULL_TURN;
                end
            end
            C_FOLD: begin
                r_neg <= fold_neg;
                r_x   <= X_START;
                r_y   <= '0;
                r_z   <= {fold_t, 16'b0};
            end
            C_ITER: begin
                r_i <= r_i + 1'b1;
                if (r_vec) begin
                    if (r_y >= 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end
                end else begin
                    if (r_z >= 0) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end
                end
            end
            C_POST: begin
                r_rsp.cos_v <= r_neg ? -c_cl : c_cl;
                r_rsp.sin_v <= r_neg ? -s_cl : s_cl;
                r_rsp.angle <= r_zero ? '0 : z_cl;
            end
            default: begin
                r_i <= '0;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

FILE: rtl/cmsh_back.sv
// Back part: sequencer that keeps the sliding-window sums, drives the shared
// CORDIC and the two RAMs, and issues results one at a time.
// Depends on cmsh_pkg, cmsh_ram and cmsh_cordic.
module cmsh_back #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_wdata,
    input  logic                  i_item_valid,
    input  cmsh_pkg::t_item       i_item,
    output logic                  o_item_pop,
    output logic                  o_res_valid,
    output cmsh_pkg::t_result     o_res,
    input  logic                  i_res_ready
);
    import cmsh_pkg::*;

    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int XW = ((PW > WIN_W) ? PW : WIN_W) + 1;
    localparam int CAP_RAW = (MAX_WINDOW - 2) | 1;
    localparam logic [WIN_W-1:0] CAP = (CAP_RAW > 63) ? 6'd63 : WIN_W'(CAP_RAW);
    localparam logic [PW-1:0] LAST_PTR = PW'(MAX_WINDOW - 1);
    localparam logic [XW-1:0] DEPTH_X = XW'(MAX_WINDOW);

    typedef enum logic [16:0] {
        B_IDLE      = 17'h00001,
        B_OLD_RD    = 17'h00002,
        B_OLD_GO    = 17'h00004,
        B_OLD_WAIT  = 17'h00008,
        B_NEW_GO    = 17'h00010,
        B_NEW_WAIT  = 17'h00020,
        B_VEC_GO    = 17'h00040,
        B_VEC_WAIT  = 17'h00080,
        B_DECIDE    = 17'h00100,
        B_EMIT      = 17'h00200,
        B_PEND_RD   = 17'h00400,
        B_PEND_DAT  = 17'h00800,
        B_PEND_NEXT = 17'h01000,
        B_TAIL_RD   = 17'h02000,
        B_TAIL_DAT  = 17'h04000,
        B_TAIL_NEXT = 17'h08000,
        B_FINISH    = 17'h10000
    } t_bstate;

    t_bstate           r_state;
    t_bstate           n_state;
    t_bstate           r_after;
    logic [WIN_W-1:0]  r_window;
    t_sum              r_cos_sum;
    t_sum              r_sin_sum;
    logic [WIN_W-1:0]  r_count;
    logic [WIN_W-1:0]  r_before;
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_tptr;
    t_heading          r_x;
    logic              r_last;
    t_trig             r_mean;
    logic [HALF_W-1:0] r_j;
    t_result           r_res;

    logic [WIN_W-1:0]  wsodd;
    logic [WIN_W-1:0]  w;
    logic [HALF_W-1:0] h;
    logic [HALF_W-1:0] jmax;
    logic [XW-1:0]     pe;
    logic [XW-1:0]     wx;
    logic [XW-1:0]     hx;
    logic [XW-1:0]     old_x;
    logic [XW-1:0]     tail_x;
    logic              filling;
    logic              prefix_now;
    logic              pend_now;

    logic              ring_we;
    logic [PW-1:0]     ring_raddr;
    logic [HEADING_W-1:0] ring_rdata;
    logic              pend_we;
    logic [TRIG_W-1:0] pend_rdata;

    logic              cordic_start;
    t_cordic_req       cordic_req;
    logic              cordic_done;
    t_cordic_rsp       cordic_rsp;

    always_comb begin
        wsodd  = r_window | 6'd1;
        w      = (wsodd > CAP) ? CAP : wsodd;
        h      = w[WIN_W-1:1];
        jmax   = HALF_W'(r_count - 6'd1 - {1'b0, h});
        pe     = XW'(r_wr_ptr);
        wx     = XW'(w);
        hx     = XW'(h);
        old_x  = (pe >= wx) ? pe - wx : pe + DEPTH_X - wx;
        tail_x = (pe >= hx) ? pe - hx : pe + DEPTH_X - hx;
        filling    = (r_before < w);
        prefix_now = filling && (r_count <= {1'b0, h});
        pend_now   = filling && !prefix_now && (r_count < w);
    end

    assign ring_we    = (r_state == B_NEW_GO);
    assign ring_raddr = (r_state == B_TAIL_RD) ? r_tptr : old_x[PW-1:0];
    assign pend_we    = (r_state == B_DECIDE) && pend_now;

    cmsh_ram #(
        .WIDTH (HEADING_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_x),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    cmsh_ram #(
        .WIDTH (TRIG_W),
        .DEPTH (PEND_DEPTH)
    ) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (jmax),
        .i_wdata (r_mean),
        .i_raddr (r_j),
        .o_rdata (pend_rdata)
    );

    always_comb begin
        cordic_start   = (r_state == B_OLD_GO) || (r_state == B_NEW_GO) ||
                         (r_state == B_VEC_GO);
        cordic_req.vec   = (r_state == B_VEC_GO);
        cordic_req.angle = (r_state == B_OLD_GO) ? t_heading'(ring_rdata) : r_x;
        cordic_req.xs    = r_cos_sum;
        cordic_req.ys    = r_sin_sum;
    end

    cmsh_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_req   (cordic_req),
        .o_done  (cordic_done),
        .o_rsp   (cordic_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_item_valid) begin
                    n_state = (r_count >= w) ? B_OLD_RD : B_NEW_GO;
                end
            end
            B_OLD_RD:   n_state = B_OLD_GO;
            B_OLD_GO:   n_state = B_OLD_WAIT;
            B_OLD_WAIT: n_state = cordic_done ? B_NEW_GO : B_OLD_WAIT;
            B_NEW_GO:   n_state = B_NEW_WAIT;
            B_NEW_WAIT: n_state = cordic_done ? B_VEC_GO : B_NEW_WAIT;
            B_VEC_GO:   n_state = B_VEC_WAIT;
            B_VEC_WAIT: n_state = cordic_done ? B_DECIDE : B_VEC_WAIT;
            B_DECIDE: begin
                if (pend_now) begin
                    n_state = r_last ? B_PEND_RD : B_FINISH;
                end else begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT:      n_state = i_res_ready ? r_after : B_EMIT;
            B_PEND_RD:   n_state = B_PEND_DAT;
            B_PEND_DAT:  n_state = B_EMIT;
            B_PEND_NEXT: n_state = B_PEND_RD;
            B_TAIL_RD:   n_state = B_TAIL_DAT;
            B_TAIL_DAT:  n_state = B_EMIT;
            B_TAIL_NEXT: n_state = B_TAIL_RD;
            B_FINISH:    n_state = B_IDLE;
            default:     n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_window  <= 6'd5;
            r_cos_sum <= '0;
            r_sin_sum <= '0;
            r_count   <= '0;
            r_wr_ptr  <= '0;
        end else if (i_cfg_we) begin
            r_window  <= i_cfg_wdata;
            r_cos_sum <= '0;
            r_sin_sum <= '0;
            r_count   <= '0;
            r_wr_ptr  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                B_OLD_WAIT: begin
                    if (cordic_done) begin
                        r_cos_sum <= r_cos_sum - SUM_W'(cordic_rsp.cos_v);
                        r_sin_sum <= r_sin_sum - SUM_W'(cordic_rsp.sin_v);
                    end
                end
                B_NEW_GO: begin
                    r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
                end
                B_NEW_WAIT: begin
                    if (cordic_done) begin
                        r_cos_sum <= r_cos_sum + SUM_W'(cordic_rsp.cos_v);
                        r_sin_sum <= r_sin_sum + SUM_W'(cordic_rsp.sin_v);
                        if (filling) begin
                            r_count <= r_before + 6'd1;
                        end
                    end
                end
                B_FINISH: begin
                    if (r_last) begin
                        r_cos_sum <= '0;
                        r_sin_sum <= '0;
                        r_count   <= '0;
                        r_wr_ptr  <= '0;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_x      <= i_item.heading;
                r_last   <= i_item.last;
                r_before <= r_count;
            end
            B_VEC_WAIT: begin
                r_mean <= cordic_rsp.angle;
            end
            B_DECIDE: begin
                r_j    <= '0;
                r_tptr <= tail_x[PW-1:0];
                r_res  <= '{heading: HEADING_W'(r_mean), smoothed: 1'b1,
                            last: r_last && (prefix_now || (h == '0))};
                if (prefix_now || !r_last || (h == '0)) begin
                    r_after <= B_FINISH;
                end else begin
                    r_after <= B_TAIL_RD;
                end
            end
            B_PEND_DAT: begin
                r_res   <= '{heading: HEADING_W'(signed'(pend_rdata)), smoothed: 1'b1,
                             last: (r_j == jmax)};
                r_after <= (r_j == jmax) ? B_FINISH : B_PEND_NEXT;
            end
            B_PEND_NEXT: begin
                r_j <= r_j + 1'b1;
            end
            B_TAIL_DAT: begin
                r_res   <= '{heading: t_heading'(ring_rdata), smoothed: 1'b0,
                             last: (r_j == h - 1'b1)};
                r_after <= (r_j == h - 1'b1) ? B_FINISH : B_TAIL_NEXT;
            end
            B_TAIL_NEXT: begin
                r_j    <= r_j + 1'b1;
                r_tptr <= (r_tptr == LAST_PTR) ? '0 : r_tptr + 1'b1;
            end
            default: begin
                r_j <= r_j;
            end
        endcase
    end

    assign o_item_pop  = (r_state == B_IDLE) && !i_cfg_we;
    assign o_res_valid = (r_state == B_EMIT);
    assign o_res       = r_res;

endmodule

FILE: rtl/circular_mean_heading_smoother_top.sv
// Top level of the circular mean heading smoother: input queue, back
// sequencer and the output register. Depends on cmsh_pkg, cmsh_front, cmsh_back.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[16:0] heading_in, tlast last_sample
//   m_axis   out        tdata[16:0] heading_out, tuser smoothed, tlast last_result
//   cfg      in         i_cfg_wdata[5:0] window_size, written when i_cfg_we is high
//
// With a full window a request makes three passes through the one shared
// CORDIC unit; while the window fills the subtraction pass is skipped.
// A final request also flushes the extra results that it holds.
// Reset is synchronous and active low; the window resets to 5. The two-entry
// input queue and the output register let either side stall on its own.
module circular_mean_heading_smoother_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [16:0] heading_in, [23:17] zero
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] heading_out, [23:17] zero
    output logic        m_axis_tuser,   // [0] smoothed
    output logic        m_axis_tlast
);
    import cmsh_pkg::*;

    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    q_pop;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    // The output register: one finished result waits here while the back
    // sequencer is already free to move on.
    logic    r_out_valid;
    t_result r_out;

    assign in_item.heading = s_axis_tdata[HEADING_W-1:0];
    assign in_item.last    = s_axis_tlast;

    cmsh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (in_item),
        .o_ready (s_axis_tready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    cmsh_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    // The slot is free when empty or when its result is taken this cycle.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.heading};
    assign m_axis_tuser  = r_out.smoothed;
    assign m_axis_tlast  = r_out.last;

endmodule

FILE: test/cmsh_heading_checker.sv
// Checker for the circular mean heading smoother: it watches the cfg, s_axis and m_axis
// channels, predicts each result from its own model of the block and compares them.
// Depends on cmsh_pkg for the result type and the arctangent table.
module cmsh_heading_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [23:0] i_s_data,
    input  logic        i_s_last,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [23:0] i_m_data,
    input  logic        i_m_user,
    input  logic        i_m_last,
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_checked
);
    import cmsh_pkg::*;

    localparam int RING_DEPTH = 64;

    logic [5:0]        window_reg;
    t_heading          heading_ring [RING_DEPTH];
    int                cos_total;
    int                sin_total;
    int                fill_count;
    int                ring_wr;
    int                held_means [PEND_DEPTH];
    t_result           heading_expect_q [$];

    function automatic void unit_vector(input int angle, output int cv, output int sv);
        int     r;
        bit     flip;
        longint x, y, z, dx, dy;
        r = angle % 36000;
        flip = 0;
        x = 652032875;
        y = 0;
        if (r < 0) r += 36000;
        if (r >= 18000) r -= 36000;
        if (r > 9000) begin
            r -= 18000;
            flip = 1;
        end else if (r < -9000) begin
            r += 18000;
            flip = 1;
        end
        z = longint'(r) * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        cv = (x > 32767) ? 32767 : (x < -32767) ? -32767 : int'(x);
        sv = (y > 32767) ? 32767 : (y < -32767) ? -32767 : int'(y);
        if (flip) begin
            cv = -cv;
            sv = -sv;
        end
    endfunction

    // Angle of the summed vector, rounded to whole hundredths.
    function automatic int vector_angle(input int ys, input int xs);
        longint x, y, z, dx, dy;
        x = longint'(xs) * 256;
        y = longint'(ys) * 256;
        z = 0;
        if (xs == 0 && ys == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = (ys >= 0) ? 64'sd1179648000 : -64'sd1179648000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        z = (z + 32768) >>> 16;
        return (z > 18000) ? 18000 : (z < -18000) ? -18000 : int'(z);
    endfunction

    task automatic clear_path();
        cos_total = 0;
        sin_total = 0;
        fill_count = 0;
        ring_wr = 0;
    endtask

    task automatic add_expected(input int v, input bit sm, input bit lst);
        t_result r;
        r.heading = t_heading'(v);
        r.smoothed = sm;
        r.last = lst;
        heading_expect_q.insert(heading_expect_q.size(), r);
    endtask

    task automatic predict_smoothed(input t_heading x, input bit lst);
        int w, h, prior, c, cv, sv, m, idx;
        w = int'(window_reg) | 1;
        if (w > 63) w = 63;
        h = (w - 1) / 2;
        prior = fill_count;
        if (prior >= w) begin
            unit_vector(heading_ring[(ring_wr + RING_DEPTH - w) % RING_DEPTH], cv, sv);
            cos_total -= cv;
            sin_total -= sv;
        end
        heading_ring[ring_wr] = x;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        unit_vector(x, cv, sv);
        cos_total += cv;
        sin_total += sv;
        if (prior < w) fill_count = prior + 1;
        c = fill_count;
        m = vector_angle(sin_total, cos_total);
        if (prior < w && c <= h) begin
            add_expected(m, 1, lst);
        end else if (prior < w && c < w) begin
            // Prefix means past the half window are held; they come out only if the path ends first.
            held_means[(c - 1 - h) % PEND_DEPTH] = m;
            if (lst) begin
                for (int j = 0; j + h + 1 <= c; j++)
                    add_expected(held_means[j % PEND_DEPTH], 1, j + h + 1 == c);
            end
        end else begin
            add_expected(m, 1, lst && h == 0);
            if (lst) begin
                for (int j = 0; j < h; j++) begin
                    idx = (ring_wr + RING_DEPTH - h + j) % RING_DEPTH;
                    add_expected(heading_ring[idx], 0, j + 1 == h);
                end
            end
        end
        if (lst) clear_path();
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            window_reg = 6'd5;
            clear_path();
            heading_expect_q.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                window_reg = i_cfg_wdata;
                clear_path();
            end
            if (i_s_valid && i_s_ready)
                predict_smoothed(t_heading'(i_s_data[16:0]), i_s_last);
            if (i_m_valid && i_m_ready) begin
                if (heading_expect_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: heading %0d smoothed %0b last %0b",
                                 $signed(i_m_data[16:0]), i_m_user, i_m_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = heading_expect_q.pop_front();
                    if (i_m_data !== {7'd0, want.heading} || i_m_user !== want.smoothed
                        || i_m_last !== want.last) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.heading, want.smoothed, want.last,
                                     $signed(i_m_data[16:0]), i_m_user, i_m_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
                o_checked <= o_checked + 1;
            end
        end
        o_waiting <= heading_expect_q.size();
    end

endmodule

FILE: test/circular_mean_heading_smoother_top_test.sv
// Testbench top for the circular mean heading smoother: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on cmsh_pkg, the block's top
// level and cmsh_heading_checker, which does all prediction and comparison.
module circular_mean_heading_smoother_top_test;
    import cmsh_pkg::*;

    // Cycles without any accepted request before the run is declared hung. The
    // slowest legal gap is a long receiver hold-off on top of a full flush.
    localparam int IDLE_LIMIT = 6000;
    // Quiet time before a window write, long enough for a request that
    // produces no result to leave the block.
    localparam int SETTLE_CYCLES = 300;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [5:0]  i_cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 0;   // [16:0] heading_in, [23:17] zero
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;       // [16:0] heading_out, [23:17] zero
    logic        m_axis_tuser;       // [0] smoothed
    logic        m_axis_tlast;

    int fail_count, waiting, checked;
    int sent_total = 0;
    int window_writes = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_go = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    circular_mean_heading_smoother_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    cmsh_heading_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_last(s_axis_tlast),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_user(m_axis_tuser), .i_m_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_waiting(waiting), .o_checked(checked)
    );

    // The receiver steps through stall patterns of its own, one after another:
    // always ready, coin flip, mostly stalled and alternating. A hold-off request
    // from the stimulus holds ready low for a long stretch so the block backs up.
    initial begin
        int tick;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_go) begin
                hold_go = 0;
                m_axis_tready <= 0;
                repeat (500) @(posedge i_clk);
            end else begin
                case ((tick / 64) % 4)
                    0: m_axis_tready <= 1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= tick[0];
                endcase
            end
        end
    end

    // Watchdog: any accepted request on either channel resets the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("circular_mean_heading_smoother_top regression: fail");
            $finish;
        end
    end

    // Offers one request and returns once it is accepted. Valid stays high so
    // the next request can follow back to back; it drops only for a gap.
    task automatic send_heading(input int heading, input bit lst);
        if (burst_left == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata <= {7'd0, heading[16:0]};
        s_axis_tlast <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_total++;
    endtask

    // The sender stops until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 0;
        burst_left = 0;
        do @(posedge i_clk); while (waiting != 0);
    endtask

    // A window write happens only with the block idle; it also restarts the path.
    task automatic write_window(input logic [5:0] w);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 0;
        window_writes++;
    endtask

    initial begin
        logic [5:0] win_list [10];
        int         w, path_len, heading, pick;
        bit         cut_short;

        win_list = '{6'd0, 6'd63, 6'd2, 6'd1, 6'd62, 6'd6, 6'd17, 6'd9, 6'd3, 6'd5};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part at the reset window of five: range extremes on a
        // full-window path, then a path shorter than the window that uses
        // headings beyond one turn, then a path of one sample.
        send_heading(0, 0);
        send_heading(36000, 0);
        send_heading(-36000, 0);
        send_heading(18000, 0);
        send_heading(-18000, 0);
        send_heading(9000, 0);
        send_heading(-9000, 1);
        send_heading(65535, 0);
        send_heading(-65536, 0);
        send_heading(12345, 1);
        send_heading(100, 1);

        // Opposite headings cancel, so the summed vector is zero.
        write_window(6'd3);
        send_heading(0, 0);
        send_heading(18000, 1);

        // A path left open is dropped by the next window write; window one
        // then averages nothing and the last flag rides on the mean itself.
        send_heading(500, 0);
        send_heading(600, 0);
        write_window(6'd0);
        send_heading(7000, 0);
        send_heading(-7000, 1);

        // Random part: whole paths with random content under a rotating window
        // setting, some paths cut short by the next write, a few noisy headings.
        // The long receiver hold-off comes under window one, where every
        // request gives a result, so the block really backs up.
        pick = 0;
        while (sent_total < 150) begin
            write_window(win_list[pick % 10]);
            w = int'(win_list[pick % 10]) | 1;
            for (int p = 0; p < 3; p++) begin
                path_len = $urandom_range(1, (w + 8 > 40) ? 40 : w + 8);
                cut_short = (p == 2) && ($urandom_range(0, 3) == 0);
                if (pick == 0 && p == 0) hold_go = 1;
                for (int k = 0; k < path_len && sent_total < 150; k++) begin
                    if ($urandom_range(0, 9) < 8)
                        heading = $urandom_range(0, 72000) - 36000;
                    else
                        heading = $urandom_range(0, 131071) - 65536;
                    send_heading(heading, (k == path_len - 1) && !cut_short);
                end
            end
            pick++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d heading requests and %0d results over %0d window settings,",
                 sent_total, checked, window_writes);
        $display("including short paths, zero vectors, open paths and a long output stall.");
        if (fail_count == 0 && waiting == 0) begin
            $display("circular_mean_heading_smoother_top regression: pass");
        end else begin
            $display("circular_mean_heading_smoother_top regression: fail");
        end
        $finish;
    end

endmodule
